>>> rtl/arp_pkg.sv
// Shared types, register indexes, zone codes and divide-by-255 helpers for the ring shader.
`default_nettype none
package arp_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CENTER_X     = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y     = 3'd1;
  localparam logic [2:0] CFG_RADIUS       = 3'd2;
  localparam logic [2:0] CFG_STROKE_WIDTH = 3'd3;
  localparam logic [2:0] CFG_STROKE_MODE  = 3'd4;
  localparam logic [2:0] CFG_FILL_COLOR   = 3'd5;
  localparam logic [2:0] CFG_STROKE_COLOR = 3'd6;
  localparam logic [2:0] CFG_BACK_COLOR   = 3'd7;

  // Stroke placement modes.
  localparam logic [1:0] MODE_OUTSIDE = 2'd0;
  localparam logic [1:0] MODE_CENTER  = 2'd1;
  localparam logic [1:0] MODE_INSIDE  = 2'd2;

  // Pixel zones.
  localparam logic [2:0] ZONE_BACK   = 3'd0;
  localparam logic [2:0] ZONE_OUTER  = 3'd1;
  localparam logic [2:0] ZONE_FILL   = 3'd2;
  localparam logic [2:0] ZONE_INNER  = 3'd3;
  localparam logic [2:0] ZONE_STROKE = 3'd4;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Sideband that rides along the divider.
  typedef struct packed {
    logic       is_edge;
    logic [7:0] res_a;
    logic [7:0] flat_a;
    rgb_t       flat;
    rgb_t       dst;
  } dside_t;

  // Floor of y / 255, exact for y below 65280 (255 * 256), where the quotient still fits in 8 bits.
  function automatic logic [7:0] div255_floor(input logic [16:0] y);
    logic [17:0] t;
    t = 18'(y) + 18'd1 + 18'(y >> 8);
    return t[15:8];
  endfunction

  // Rounded x / 255 for x up to 255 * 255.
  function automatic logic [7:0] div255_round(input logic [15:0] x);
    logic [16:0] y;
    y = 17'(x) + 17'd127;
    return div255_floor(y);
  endfunction

  // Channel of a packed R,G,B,A word: 0 red, 1 green, 2 blue.
  function automatic logic [7:0] col_chan(input logic [31:0] c, input logic [1:0] k);
    logic [7:0] v;
    case (k)
      2'd0:    v = c[31:24];
      2'd1:    v = c[23:16];
      default: v = c[15:8];
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/arp_isqrt.sv
// Pipelined integer square root, one root bit resolved per stage.
`default_nettype none
module arp_isqrt import arp_pkg::*; #(
  parameter int IN_W   = 35,
  parameter int SIDE_W = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic [IN_W-1:0]          in_rad,
  input  wire logic [SIDE_W-1:0]        in_side,
  output logic                          out_valid,
  output logic [(IN_W+1)/2-1:0]         out_root,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int RW = (IN_W + 1) / 2;

  logic [2*RW-1:0]   rad  [0:RW];
  logic [RW+1:0]     rem  [0:RW];
  logic [RW-1:0]     root [0:RW];
  logic              vld  [0:RW];
  logic [SIDE_W-1:0] side [0:RW];

  assign rad[0]  = (2*RW)'(in_rad);
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign vld[0]  = in_valid;
  assign side[0] = in_side;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+3:0] pre;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    // Bring down the next two radicand bits and try the next root bit.
    assign pre   = {rem[k], rad[k][2*RW-1:2*RW-2]};
    assign trial = {2'b00, root[k], 2'b01};
    assign diff  = pre - trial;
    assign ge    = (pre >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rad[k+1]  <= rad[k] << 2;
      rem[k+1]  <= ge ? diff[RW+1:0] : pre[RW+1:0];
      root[k+1] <= {root[k][RW-2:0], ge};
      side[k+1] <= side[k];
    end
  end

  assign out_valid = vld[RW];
  assign out_root  = root[RW];
  assign out_side  = side[RW];

endmodule
`default_nettype wire

>>> rtl/arp_div.sv
// Pipelined restoring divider, several numerators over one shared divisor.
`default_nettype none
module arp_div import arp_pkg::*; #(
  parameter int NUM_W  = 24,
  parameter int DEN_W  = 8,
  parameter int LANES  = 6,
  parameter int SIDE_W = 73
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic [LANES-1:0][NUM_W-1:0]     in_num,
  input  wire logic [DEN_W-1:0]                in_den,
  input  wire logic [SIDE_W-1:0]               in_side,
  output logic                                 out_valid,
  output logic [LANES-1:0][NUM_W-1:0]          out_quo,
  output logic [SIDE_W-1:0]                    out_side
);

  logic [LANES-1:0][NUM_W-1:0] nq   [0:NUM_W];
  logic [LANES-1:0][DEN_W-1:0] rem  [0:NUM_W];
  logic [DEN_W-1:0]            den  [0:NUM_W];
  logic                        vld  [0:NUM_W];
  logic [SIDE_W-1:0]           side [0:NUM_W];

  assign nq[0]   = in_num;
  assign rem[0]  = '0;
  assign den[0]  = in_den;
  assign vld[0]  = in_valid;
  assign side[0] = in_side;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [LANES-1:0][NUM_W-1:0] nq_next;
    logic [LANES-1:0][DEN_W-1:0] rem_next;

    // One quotient bit per lane: shift in a numerator bit and subtract if it fits.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] pre;
      logic [DEN_W:0] diff;
      logic           ge;
      assign pre  = {rem[k][l], nq[k][l][NUM_W-1]};
      assign diff = pre - {1'b0, den[k]};
      assign ge   = (pre >= {1'b0, den[k]});
      assign rem_next[l] = ge ? diff[DEN_W-1:0] : pre[DEN_W-1:0];
      assign nq_next[l]  = {nq[k][l][NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      nq[k+1]   <= nq_next;
      rem[k+1]  <= rem_next;
      den[k+1]  <= den[k];
      side[k+1] <= side[k];
    end
  end

  assign out_valid = vld[NUM_W];
  assign out_quo   = nq[NUM_W];
  assign out_side  = side[NUM_W];

endmodule
`default_nettype wire

>>> rtl/antialiased_ring_pixel_shader_top.sv
// Top level of the antialiased ring pixel shader: config registers and pixel pipeline.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-------------------------------------------
//   pixel in  | start, busy        | pix_x, pix_y, dst_blue, dst_green, dst_red
//   pixel out | done (one cycle)   | out_blue, out_green, out_red
//   config    | wr_en              | wr_index, wr_data
//
// While busy is low one request is taken every clock. Each result's latency is set by
// the square root pipeline (one root bit per stage, for a root of RW bits, where
// RW = max(COORD_BITS + FRAC_BITS, 16) + 2, 18 by default) and the 24-stage divider
// that normalizes the edge colours by the merged alpha.
// Reset is synchronous; busy is high in each cycle after a reset cycle, else low.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module antialiased_ring_pixel_shader_top import arp_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_BITS-1:0] pix_x,
  input  wire logic [COORD_BITS-1:0] pix_y,
  input  wire logic [7:0]            dst_blue,
  input  wire logic [7:0]            dst_green,
  input  wire logic [7:0]            dst_red,
  output logic                       done,
  output logic [7:0]                 out_blue,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_red,
  input  wire logic                  wr_en,
  input  wire logic [2:0]            wr_index,
  input  wire logic [31:0]           wr_data
);

  localparam int PW      = COORD_BITS + FRAC_BITS;
  localparam int OW      = ((PW > 16) ? PW : 16) + 1;
  localparam int SW      = 2 * OW + 1;
  localparam int RW      = (SW + 1) / 2;
  localparam int CMP_W   = ((RW > 18) ? RW : 18) + 2;
  localparam int RP_W    = FRAC_BITS + 9;
  localparam int NUM_W   = 24;
  localparam int LANES_C = 6;
  localparam int LATENCY = RW + 37;

  // Configuration registers.
  logic [15:0] center_x, center_y, radius, stroke_width;
  logic [1:0]  stroke_mode;
  logic [31:0] fill_color, stroke_color, back_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      radius       <= '0;
      stroke_width <= '0;
      stroke_mode  <= '0;
      fill_color   <= '0;
      stroke_color <= '0;
      back_color   <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_CENTER_X:     center_x     <= wr_data[15:0];
        CFG_CENTER_Y:     center_y     <= wr_data[15:0];
        CFG_RADIUS:       radius       <= wr_data[15:0];
        CFG_STROKE_WIDTH: stroke_width <= wr_data[15:0];
        CFG_STROKE_MODE:  stroke_mode  <= wr_data[1:0];
        CFG_FILL_COLOR:   fill_color   <= wr_data;
        CFG_STROKE_COLOR: stroke_color <= wr_data;
        CFG_BACK_COLOR:   back_color   <= wr_data;
        default:          ;
      endcase
    end
  end

  // Busy during and right after reset.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  logic accept;
  assign accept = start && !busy;

  // Stage A: offsets from the centre; a pixel at or past the centre gets one extra pixel.
  logic [OW-1:0] px, py, cx, cy, one_o, dx_next, dy_next;
  assign px    = OW'(pix_x) << FRAC_BITS;
  assign py    = OW'(pix_y) << FRAC_BITS;
  assign cx    = OW'(center_x);
  assign cy    = OW'(center_y);
  assign one_o = OW'(1) << FRAC_BITS;
  assign dx_next = (px >= cx) ? (px - cx + one_o) : (cx - px);
  assign dy_next = (py >= cy) ? (py - cy + one_o) : (cy - py);

  logic          a_valid;
  logic [OW-1:0] a_dx, a_dy;
  rgb_t          a_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
    a_dx  <= dx_next;
    a_dy  <= dy_next;
    a_dst <= '{r: dst_red, g: dst_green, b: dst_blue};
  end

  // Stage B: squares.
  logic            b_valid;
  logic [2*OW-1:0] b_sqx, b_sqy;
  rgb_t            b_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_sqx <= (2*OW)'(a_dx) * (2*OW)'(a_dx);
    b_sqy <= (2*OW)'(a_dy) * (2*OW)'(a_dy);
    b_dst <= a_dst;
  end

  // Stage C: sum of squares.
  logic          c_valid;
  logic [SW-1:0] c_sum;
  rgb_t          c_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_sum <= SW'(b_sqx) + SW'(b_sqy);
    c_dst <= b_dst;
  end

  // Square root pipeline.
  logic          q_valid;
  logic [RW-1:0] q_root;
  rgb_t          q_dst;

  arp_isqrt #(
    .IN_W   (SW),
    .SIDE_W ($bits(rgb_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_rad    (c_sum),
    .in_side   (c_dst),
    .out_valid (q_valid),
    .out_root  (q_root),
    .out_side  (q_dst)
  );

  // Stage D: ring geometry and zone classification.
  logic [16:0]              outer_u;
  logic signed [CMP_W-1:0]  dis_s, outer_s, inner_s, one_s, diff_o, diff_i;
  logic [2:0]               zone_next;
  logic [FRAC_BITS:0]       rem_next;

  always_comb begin
    unique case (stroke_mode)
      MODE_CENTER: outer_u = 17'(radius) + 17'(stroke_width >> 1);
      MODE_INSIDE: outer_u = 17'(radius);
      default:     outer_u = 17'(radius) + 17'(stroke_width);
    endcase
  end

  assign dis_s   = $signed(CMP_W'(q_root));
  assign outer_s = $signed(CMP_W'(outer_u));
  assign inner_s = outer_s - $signed(CMP_W'(stroke_width));
  assign one_s   = $signed(CMP_W'(one_o));
  assign diff_o  = dis_s - outer_s;
  assign diff_i  = dis_s - inner_s;

  always_comb begin
    rem_next = diff_i[FRAC_BITS:0];
    if (dis_s >= outer_s + one_s) begin
      zone_next = ZONE_BACK;
    end else if (dis_s > outer_s) begin
      zone_next = ZONE_OUTER;
      rem_next  = diff_o[FRAC_BITS:0];
    end else if (dis_s <= inner_s) begin
      zone_next = ZONE_FILL;
    end else if (dis_s <= inner_s + one_s) begin
      zone_next = ZONE_INNER;
    end else begin
      zone_next = ZONE_STROKE;
    end
  end

  logic               d_valid;
  logic [2:0]         d_zone;
  logic [FRAC_BITS:0] d_rem;
  rgb_t               d_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= q_valid;
    end
    d_zone <= zone_next;
    d_rem  <= rem_next;
    d_dst  <= q_dst;
  end

  // Stage E: coverage and the two weight products.
  logic [RP_W-1:0] rem255;
  logic [7:0]      cov, w_a, w_ca, oth_a;
  assign rem255 = (RP_W'(d_rem) << 8) - RP_W'(d_rem);
  assign cov    = rem255[FRAC_BITS+7:FRAC_BITS];
  assign w_a    = (d_zone == ZONE_OUTER) ? (8'd255 - cov) : cov;
  assign w_ca   = (d_zone == ZONE_OUTER) ? cov : (8'd255 - cov);
  assign oth_a  = (d_zone == ZONE_OUTER) ? back_color[7:0] : fill_color[7:0];

  logic        e_valid;
  logic [2:0]  e_zone;
  logic [15:0] e_pa, e_pca;
  rgb_t        e_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= d_valid;
    end
    e_zone <= d_zone;
    e_pa   <= 16'(stroke_color[7:0]) * 16'(w_a);
    e_pca  <= 16'(oth_a) * 16'(w_ca);
    e_dst  <= d_dst;
  end

  // Stage F: scaled alphas.
  logic       f_valid;
  logic [2:0] f_zone;
  logic [7:0] f_a, f_ca;
  rgb_t       f_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= e_valid;
    end
    f_zone <= e_zone;
    f_a    <= div255_round(e_pa);
    f_ca   <= div255_round(e_pca);
    f_dst  <= e_dst;
  end

  // Stage G: product of the inverse alphas.
  logic        g_valid;
  logic [2:0]  g_zone;
  logic [7:0]  g_a, g_ca;
  logic [15:0] g_pr;
  rgb_t        g_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else begin
      g_valid <= f_valid;
    end
    g_zone <= f_zone;
    g_a    <= f_a;
    g_ca   <= f_ca;
    g_pr   <= 16'(8'd255 - f_a) * 16'(8'd255 - f_ca);
    g_dst  <= f_dst;
  end

  // Stage H: merged alpha.
  logic       h_valid;
  logic [2:0] h_zone;
  logic [7:0] h_a, h_ca, h_res_a;
  rgb_t       h_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else begin
      h_valid <= g_valid;
    end
    h_zone  <= g_zone;
    h_a     <= g_a;
    h_ca    <= g_ca;
    h_res_a <= 8'd255 - div255_round(g_pr);
    h_dst   <= g_dst;
  end

  // Stage I: stroke channel times its weight, and the other colour's weight.
  logic             i_valid;
  logic [2:0]       i_zone;
  logic [7:0]       i_res_a;
  logic [2:0][15:0] i_sa;
  logic [15:0]      i_cw;
  rgb_t             i_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else begin
      i_valid <= h_valid;
    end
    i_zone  <= h_zone;
    i_res_a <= h_res_a;
    for (int k = 0; k < 3; k++) begin
      i_sa[k] <= 16'(col_chan(stroke_color, 2'(k))) * 16'(h_a);
    end
    i_cw  <= 16'(h_ca) * 16'(8'd255 - h_a);
    i_dst <= h_dst;
  end

  // Stage J: divider numerators, divisor and flat-zone colour.
  logic [31:0]                   oth_col, flat_col;
  logic [LANES_C-1:0][NUM_W-1:0] num_next;

  assign oth_col = (i_zone == ZONE_OUTER) ? back_color : fill_color;

  always_comb begin
    case (i_zone)
      ZONE_BACK: flat_col = back_color;
      ZONE_FILL: flat_col = fill_color;
      default:   flat_col = stroke_color;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_next[k]     = (NUM_W'(i_sa[k]) << 8) - NUM_W'(i_sa[k]);
      num_next[k + 3] = NUM_W'(col_chan(oth_col, 2'(k))) * NUM_W'(i_cw);
    end
  end

  logic                          j_valid;
  logic [LANES_C-1:0][NUM_W-1:0] j_num;
  logic [7:0]                    j_den;
  dside_t                        j_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_valid <= 1'b0;
    end else begin
      j_valid <= i_valid;
    end
    j_num          <= num_next;
    j_den          <= (i_res_a == 8'd0) ? 8'd1 : i_res_a;
    j_side.is_edge <= (i_zone == ZONE_OUTER) || (i_zone == ZONE_INNER);
    j_side.res_a   <= i_res_a;
    j_side.flat_a  <= flat_col[7:0];
    j_side.flat    <= '{r: flat_col[31:24], g: flat_col[23:16], b: flat_col[15:8]};
    j_side.dst     <= i_dst;
  end

  // Divide both colour terms by the merged alpha.
  logic                          v_valid;
  logic [LANES_C-1:0][NUM_W-1:0] v_quo;
  dside_t                        v_side;

  arp_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (8),
    .LANES  (LANES_C),
    .SIDE_W ($bits(dside_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (j_valid),
    .in_num    (j_num),
    .in_den    (j_den),
    .in_side   (j_side),
    .out_valid (v_valid),
    .out_quo   (v_quo),
    .out_side  (v_side)
  );

  // Stage K: sum, divide by 255 with saturation, pick edge or flat colour.
  logic [2:0][7:0] edge_ch;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [NUM_W:0] sum;
      sum = (NUM_W+1)'(v_quo[k]) + (NUM_W+1)'(v_quo[k + 3]);
      if (sum >= (NUM_W+1)'(65280)) begin
        edge_ch[k] = 8'd255;
      end else begin
        edge_ch[k] = div255_floor(sum[16:0]);
      end
    end
  end

  logic       k_valid;
  logic [7:0] k_alpha;
  rgb_t       k_col;
  rgb_t       k_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_valid <= 1'b0;
    end else begin
      k_valid <= v_valid;
    end
    if (v_side.is_edge) begin
      k_alpha <= v_side.res_a;
      k_col   <= '{r: edge_ch[0], g: edge_ch[1], b: edge_ch[2]};
    end else begin
      k_alpha <= v_side.flat_a;
      k_col   <= v_side.flat;
    end
    k_dst <= v_side.dst;
  end

  // Stage L: blend products over the destination.
  logic [2:0][7:0] k_col_a, k_dst_a;
  assign k_col_a = {k_col.b, k_col.g, k_col.r};
  assign k_dst_a = {k_dst.b, k_dst.g, k_dst.r};

  logic             l_valid;
  logic [2:0][15:0] l_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid <= 1'b0;
    end else begin
      l_valid <= k_valid;
    end
    for (int k = 0; k < 3; k++) begin
      l_sum[k] <= 16'(k_alpha) * 16'(k_col_a[k])
                + 16'(8'd255 - k_alpha) * 16'(k_dst_a[k]);
    end
  end

  // Stage M: rounded divide and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= l_valid;
    end
    out_red   <= div255_round(l_sum[0]);
    out_green <= div255_round(l_sum[1]);
    out_blue  <= div255_round(l_sum[2]);
  end

endmodule
`default_nettype wire

>>> rtl/arp_checker.sv
// Port-level checker for the ring shader and its bind to the top level.
`default_nettype none
module arp_checker #(
  parameter int LAT = 55
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // Busy is raised in the cycle after reset.
  a_busy_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("busy not raised after reset");

  a_busy_clears: assert property (@(posedge clk) !rst |=> !busy)
    else $error("busy high outside reset recovery");

  // Reset flushes the pipeline: no result right after it.
  a_no_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // Every result traces back to an accepted request; the bind sets LAT from LATENCY.
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching request");

endmodule

bind antialiased_ring_pixel_shader_top arp_checker #(.LAT(LATENCY)) u_arp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
`default_nettype wire
